>>> rtl/core/cross_feedback_stereo_delay_defines.svh
// Assertion macros shared by the delay core.
`ifndef CROSS_FEEDBACK_STEREO_DELAY_DEFINES_SVH
`define CROSS_FEEDBACK_STEREO_DELAY_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CFSD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define CFSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/cfsd_pkg.sv
`timescale 1ns / 1ps

package cfsd_pkg;

    localparam int DELAY_DEPTH = 32768;
    localparam int ADDR_W      = $clog2(DELAY_DEPTH);
    localparam int LEN_W       = ADDR_W + 1;
    localparam int SAMPLE_W    = 16;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 3;

    // Wide enough for tap * gain plus the rounding and dry terms.
    localparam int ACC_W       = 26;

    localparam logic [7:0] GAIN_MAX  = 8'd128;
    localparam logic [8:0] FB_ZERO   = 9'd64;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [ADDR_W-1:0]          addr_t;
    typedef logic signed [ACC_W-1:0]    acc_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEFT_LENGTH    = 3'd0,
        CFG_RIGHT_LENGTH   = 3'd1,
        CFG_FEEDBACK_LEVEL = 3'd2,
        CFG_WET_LEVEL      = 3'd3,
        CFG_DRY_THRU       = 3'd4
    } cfg_index_t;

    // io_mode bit positions
    localparam int MODE_IN_BIT  = 0;
    localparam int MODE_OUT_BIT = 1;

endpackage

>>> rtl/core/cross_feedback_stereo_delay.sv
`timescale 1ns / 1ps
`include "cross_feedback_stereo_delay_defines.svh"

// Channel   | Signals                               | Carries
// ----------+---------------------------------------+-------------------------------
// s_*       | s_tvalid s_tready s_tdata s_tuser     | mono sample in, io_mode
// m_*       | m_tvalid m_tready m_tdata             | left and right samples out
// cfg_*     | cfg_we cfg_index cfg_data             | register write, no read-back
//
// One request per cycle is accepted unless m_tready stalls; a result passes through
// the compute and output stage registers. The delay memories are read at accept and
// written back as the compute stage advances, with the written value forwarded when
// the next request hits the same entry. After reset a clearing pass zeroes all
// DELAY_DEPTH (32768) entries of both memories with s_tready low; register writes are
// taken during it. A stalled m_tready holds the compute stage and then s_tready.

module cross_feedback_stereo_delay
    import cfsd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,   // [15:0] sample
    input  logic [1:0]           s_tuser,   // [1:0] io_mode

    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,   // [15:0] left_out, [31:16] right_out

    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    // configuration
    logic [15:0] left_length_reg;
    logic [15:0] right_length_reg;
    logic [7:0]  feedback_level_reg;
    logic [7:0]  wet_level_reg;
    logic        dry_thru_reg;

    // position and clearing
    addr_t       left_pos_reg,  left_pos_next;
    addr_t       right_pos_reg, right_pos_next;
    logic [ADDR_W:0] clr_cnt_reg;
    logic        clearing;

    // compute stage
    logic        p_valid_reg;
    sample_t     p_sample_reg;
    logic [1:0]  p_mode_reg;
    addr_t       p_laddr_reg;
    addr_t       p_raddr_reg;
    sample_t     left_q_reg;
    sample_t     right_q_reg;
    logic        lbyp_reg;
    logic        rbyp_reg;
    sample_t     lbyp_data_reg;
    sample_t     rbyp_data_reg;

    // output stage
    logic        out_valid_reg;
    sample_t     left_out_reg,  left_out_next;
    sample_t     right_out_reg, right_out_next;

    sample_t     left_mem  [DELAY_DEPTH];
    sample_t     right_mem [DELAY_DEPTH];

    logic        accept;
    logic        p_advance;
    logic        item_wr;
    logic        mem_we;
    addr_t       wr_laddr;
    addr_t       wr_raddr;
    sample_t     wr_ldata;
    sample_t     wr_rdata;
    addr_t       rd_laddr;
    addr_t       rd_raddr;

    logic [LEN_W-1:0] llen;
    logic [LEN_W-1:0] rlen;
    logic [7:0]  fcode;
    logic [7:0]  wcode;
    logic signed [9:0] fb_gain;
    logic signed [9:0] wet_gain;

    sample_t     ltap;
    sample_t     rtap;
    logic        has_in;
    logic        want_out;
    acc_t        x_val;
    acc_t        dry_val;
    acc_t        lfb_prod;
    acc_t        rfb_prod;
    acc_t        lwet_prod;
    acc_t        rwet_prod;
    acc_t        lfb_term;
    acc_t        rfb_term;
    acc_t        lwet_term;
    acc_t        rwet_term;
    sample_t     l_item_data;
    sample_t     r_item_data;

    function automatic logic [LEN_W-1:0] eff_len(input logic [15:0] len);
        logic [LEN_W-1:0] r;
        if (len == 16'd0)
            r = LEN_W'(1);
        else if (32'(len) > DELAY_DEPTH)
            r = LEN_W'(DELAY_DEPTH);
        else
            r = LEN_W'(len);
        return r;
    endfunction

    function automatic sample_t sat(input acc_t v);
        sample_t r;
        if (v > acc_t'({1'b0, {(SAMPLE_W-1){1'b1}}}))
            r = {1'b0, {(SAMPLE_W-1){1'b1}}};
        else if (v < -acc_t'({1'b1, {(SAMPLE_W-1){1'b0}}}))
            r = {1'b1, {(SAMPLE_W-1){1'b0}}};
        else
            r = v[SAMPLE_W-1:0];
        return r;
    endfunction

    // Wrap a position that lies at or beyond the length before use.
    function automatic addr_t wrap_pos(input addr_t pos, input logic [LEN_W-1:0] len);
        return (LEN_W'(pos) >= len) ? '0 : pos;
    endfunction

    function automatic addr_t step_pos(input addr_t pos, input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] inc;
        inc = LEN_W'(pos) + LEN_W'(1);
        return (inc >= len) ? '0 : inc[ADDR_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // handshake
    // ------------------------------------------------------------------
    assign clearing  = !clr_cnt_reg[ADDR_W];
    assign p_advance = p_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !clearing && (!p_valid_reg || p_advance);
    assign accept    = s_tvalid && s_tready;

    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {right_out_reg, left_out_reg};

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_length_reg    <= 16'd1024;
            right_length_reg   <= 16'd1024;
            feedback_level_reg <= 8'd96;
            wet_level_reg      <= 8'd48;
            dry_thru_reg       <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LEFT_LENGTH:    left_length_reg    <= cfg_data[15:0];
                CFG_RIGHT_LENGTH:   right_length_reg   <= cfg_data[15:0];
                CFG_FEEDBACK_LEVEL: feedback_level_reg <= cfg_data[7:0];
                CFG_WET_LEVEL:      wet_level_reg      <= cfg_data[7:0];
                CFG_DRY_THRU:       dry_thru_reg       <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    assign llen     = eff_len(left_length_reg);
    assign rlen     = eff_len(right_length_reg);
    assign fcode    = (feedback_level_reg > GAIN_MAX) ? GAIN_MAX : feedback_level_reg;
    assign wcode    = (wet_level_reg > GAIN_MAX) ? GAIN_MAX : wet_level_reg;
    assign fb_gain  = $signed({2'b00, fcode}) - $signed({1'b0, FB_ZERO});
    assign wet_gain = $signed({2'b00, wcode});

    // ------------------------------------------------------------------
    // read side
    // ------------------------------------------------------------------
    assign rd_laddr       = wrap_pos(left_pos_reg, llen);
    assign rd_raddr       = wrap_pos(right_pos_reg, rlen);
    assign left_pos_next  = step_pos(rd_laddr, llen);
    assign right_pos_next = step_pos(rd_raddr, rlen);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_pos_reg  <= '0;
            right_pos_reg <= '0;
            clr_cnt_reg   <= '0;
            p_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (clearing)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (accept)
            begin
                left_pos_reg  <= left_pos_next;
                right_pos_reg <= right_pos_next;
            end
            if (accept)
                p_valid_reg <= 1'b1;
            else if (p_advance)
                p_valid_reg <= 1'b0;
            if (p_advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Capture the request and forward a write-back that hits the entry being read.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p_sample_reg  <= s_tdata;
            p_mode_reg    <= s_tuser;
            p_laddr_reg   <= rd_laddr;
            p_raddr_reg   <= rd_raddr;
            lbyp_reg      <= item_wr && (wr_laddr == rd_laddr);
            rbyp_reg      <= item_wr && (wr_raddr == rd_raddr);
            lbyp_data_reg <= wr_ldata;
            rbyp_data_reg <= wr_rdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            left_mem[wr_laddr] <= wr_ldata;
        if (accept)
            left_q_reg <= left_mem[rd_laddr];
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            right_mem[wr_raddr] <= wr_rdata;
        if (accept)
            right_q_reg <= right_mem[rd_raddr];
    end

    // ------------------------------------------------------------------
    // compute stage
    // ------------------------------------------------------------------
    assign ltap     = lbyp_reg ? lbyp_data_reg : left_q_reg;
    assign rtap     = rbyp_reg ? rbyp_data_reg : right_q_reg;
    assign has_in   = p_mode_reg[MODE_IN_BIT];
    assign want_out = p_mode_reg[MODE_OUT_BIT];
    assign x_val    = has_in ? ACC_W'(p_sample_reg) : '0;
    assign dry_val  = dry_thru_reg ? x_val : '0;

    assign lfb_prod  = ACC_W'(ltap) * ACC_W'(fb_gain);
    assign rfb_prod  = ACC_W'(rtap) * ACC_W'(fb_gain);
    assign lwet_prod = ACC_W'(ltap) * ACC_W'(wet_gain);
    assign rwet_prod = ACC_W'(rtap) * ACC_W'(wet_gain);

    // round half up: add half, then arithmetic shift
    assign lfb_term  = (lfb_prod + acc_t'(32)) >>> 6;
    assign rfb_term  = (rfb_prod + acc_t'(32)) >>> 6;
    assign lwet_term = (lwet_prod + acc_t'(64)) >>> 7;
    assign rwet_term = (rwet_prod + acc_t'(64)) >>> 7;

    always_comb
    begin
        if (!has_in && !want_out)
        begin
            // idle mode: each side scales itself in place, unless the feedback gain is zero
            l_item_data = sat(lfb_term);
            r_item_data = sat(rfb_term);
            item_wr     = p_advance && (fb_gain != '0);
        end
        else
        begin
            l_item_data = sat(rfb_term + x_val);
            r_item_data = sat(lfb_term + x_val);
            item_wr     = p_advance;
        end

        if (want_out)
        begin
            left_out_next  = sat(dry_val + lwet_term);
            right_out_next = sat(dry_val + rwet_term);
        end
        else
        begin
            left_out_next  = '0;
            right_out_next = '0;
        end
    end

    assign mem_we   = clearing || item_wr;
    assign wr_laddr = clearing ? clr_cnt_reg[ADDR_W-1:0] : p_laddr_reg;
    assign wr_raddr = clearing ? clr_cnt_reg[ADDR_W-1:0] : p_raddr_reg;
    assign wr_ldata = clearing ? '0 : l_item_data;
    assign wr_rdata = clearing ? '0 : r_item_data;

    always_ff @(posedge clk)
    begin
        if (p_advance)
        begin
            left_out_reg  <= left_out_next;
            right_out_reg <= right_out_next;
        end
    end

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    `CFSD_ASSERT_NOW(a_no_accept_while_clearing, clearing, !s_tready,
        "request accepted during clearing pass")
    `CFSD_ASSERT_NOW(a_no_write_on_stall, m_tvalid && !m_tready, !item_wr,
        "delay memory written while the result is stalled")
    `CFSD_ASSERT_NOW(a_stage_holds, p_valid_reg && !p_advance, !s_tready,
        "request accepted over a held compute stage")
    `CFSD_ASSERT_NEXT(a_result_follows, p_advance, m_tvalid,
        "compute stage advanced without a result")

endmodule
